// ===== rtl/binary_max_heap_queue_unit_macros.svh =====
// assertion macros shared by the heap queue rtl
`ifndef BINARY_MAX_HEAP_QUEUE_UNIT_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock outside reset
`define BMHQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("heap queue assertion failed");

// condition in one cycle implies a property in the next
`define BMHQ_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("heap queue assertion failed");

`else

`define BMHQ_ASSERT(label, clk, rst, prop)
`define BMHQ_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== rtl/bmhq_pkg.sv =====
// types, codes and microcode table of the heap queue
package bmhq_pkg;

  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 11;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic                     is_empty;
    logic [ENTRY_W-1:0]       entry_count;
    logic                     push_dropped;
  } out_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_DONE
  } phase_t;

  // microcode step addresses
  typedef enum logic [3:0] {
    S_UP_CHK,
    S_UP_CMP,
    S_UP_DONE,
    S_POP_RD,
    S_POP_LD,
    S_DN_CHK,
    S_DN_RL,
    S_DN_CMP,
    S_DN_DONE
  } step_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_POS_ZERO,
    JC_UP_STOP,
    JC_NO_LEFT,
    JC_DN_STOP
  } jcond_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_COUNT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_RDATA,
    WR_BIG,
    WR_CUR
  } wr_sel_t;

  typedef enum logic [1:0] {
    PO_HOLD,
    PO_CLEAR,
    PO_PARENT,
    PO_BIG
  } pos_op_t;

  // one control word
  typedef struct packed {
    jcond_t  jc;
    step_t   t_true;
    step_t   t_false;
    rd_sel_t rd;
    wr_sel_t wr;
    pos_op_t po;
    logic    ld_cur;
    logic    ld_lv;
    logic    done;
  } ucw_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic pos_zero;
    logic up_stop;
    logic no_left;
    logic dn_stop;
  } cond_flags_t;

  // actions issued to the datapath this cycle
  typedef struct packed {
    rd_sel_t rd;
    wr_sel_t wr;
    pos_op_t po;
    logic    ld_cur;
    logic    ld_lv;
    logic    done;
  } seq_ctrl_t;

  localparam ucw_t UCW_NOP = '{
    jc: JC_NEVER, t_true: S_UP_CHK, t_false: S_UP_CHK,
    rd: RD_NONE, wr: WR_NONE, po: PO_HOLD,
    ld_cur: 1'b0, ld_lv: 1'b0, done: 1'b0
  };

  // the program: sift up for push, sift down for pop
  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    w = UCW_NOP;
    unique case (s)
      S_UP_CHK: begin
        w.jc = JC_POS_ZERO; w.t_true = S_UP_DONE; w.t_false = S_UP_CMP;
        w.rd = RD_PARENT;
      end
      S_UP_CMP: begin
        w.jc = JC_UP_STOP; w.t_true = S_UP_DONE; w.t_false = S_UP_CHK;
        w.wr = WR_RDATA; w.po = PO_PARENT;
      end
      S_UP_DONE: begin
        w.wr = WR_CUR; w.done = 1'b1;
      end
      S_POP_RD: begin
        w.t_false = S_POP_LD; w.rd = RD_COUNT;
      end
      S_POP_LD: begin
        w.t_false = S_DN_CHK; w.ld_cur = 1'b1; w.po = PO_CLEAR;
      end
      S_DN_CHK: begin
        w.jc = JC_NO_LEFT; w.t_true = S_DN_DONE; w.t_false = S_DN_RL;
        w.rd = RD_LEFT;
      end
      S_DN_RL: begin
        w.t_false = S_DN_CMP; w.ld_lv = 1'b1; w.rd = RD_RIGHT;
      end
      S_DN_CMP: begin
        w.jc = JC_DN_STOP; w.t_true = S_DN_DONE; w.t_false = S_DN_CHK;
        w.wr = WR_BIG; w.po = PO_BIG;
      end
      S_DN_DONE: begin
        w.wr = WR_CUR; w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/binary_max_heap_queue_unit.sv =====
// top level of the binary max-heap priority queue
//
//   channel   handshake               payload   direction
//   request   in_valid / in_ready     in_item   into the block
//   result    out_valid / out_ready   out_item  out of the block
//
// one item is worked at a time; the next is taken while a result waits in
// the output register. a push climbs until it reaches the root or a compare
// stops it; a pop moves the last entry to the root and sinks it until it
// reaches a leaf or a compare stops it. the heap ram has a single read
// port, so each microcode step issues at most one read. a dropped push, a
// pop on an empty heap and a pop of the last entry skip the sequencer and
// go straight to the done phase. reset clears the entry count, the phase,
// the sequencer and the output valid flag; the ram is never cleared, since
// no slot at or above the count is ever used. a stalled result holds the
// block in its done phase until the output register is free.
`include "binary_max_heap_queue_unit_macros.svh"

module binary_max_heap_queue_unit
  import bmhq_pkg::*;
#(
  parameter int HEAP_CAPACITY = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_item
);

  localparam int AW = $clog2(HEAP_CAPACITY);
  localparam int CW = $clog2(HEAP_CAPACITY + 1);
  localparam int XW = CW + 1;

  // control
  phase_t      phase;
  phase_t      phase_next;
  logic        accept;
  logic        is_push;
  logic        full;
  logic        empty_now;
  logic        last_one;
  logic        seq_start;
  step_t       seq_entry;
  logic        out_load;
  seq_ctrl_t   ctl;
  cond_flags_t flags;

  // datapath
  logic [CW-1:0]            cnt;
  logic [AW-1:0]            pos;
  logic signed [DATA_W-1:0] cur;
  logic signed [DATA_W-1:0] lv;
  logic signed [DATA_W-1:0] root;
  logic                     dropped;
  logic [AW-1:0]            parent;
  logic [XW-1:0]            left_w;
  logic [XW-1:0]            right_w;
  logic [XW-1:0]            cnt_w;
  logic                     right_big;
  logic signed [DATA_W-1:0] bigv;
  logic [AW-1:0]            big_idx;
  logic signed [DATA_W-1:0] top;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;
  logic signed [DATA_W-1:0] rdata;

  assign accept    = in_valid && in_ready;
  assign is_push   = in_item.req_type == REQ_PUSH;
  assign full      = cnt == CW'(HEAP_CAPACITY);
  assign empty_now = cnt == '0;
  assign last_one  = cnt == CW'(1);
  assign rdata     = $signed(ram_rdata);

  // heap index arithmetic, parent and children of the hole
  assign parent  = (pos - AW'(1)) >> 1;
  assign left_w  = XW'({pos, 1'b1});
  assign right_w = left_w + XW'(1);
  assign cnt_w   = XW'(cnt);

  // larger child, left wins a tie; rdata holds the right child here
  assign right_big = (right_w < cnt_w) && (rdata > lv);
  assign bigv      = right_big ? rdata : lv;
  assign big_idx   = right_big ? right_w[AW-1:0] : left_w[AW-1:0];

  assign flags.pos_zero = pos == '0;
  assign flags.up_stop  = cur <= rdata;
  assign flags.no_left  = left_w >= cnt_w;
  assign flags.dn_stop  = cur >= bigv;

  assign top = empty_now ? '0 : root;

  // phase next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (accept) begin
          if (is_push ? full : (empty_now || last_one)) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_RUN;
          end
        end
      end
      PH_RUN: begin
        if (ctl.done) begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        if (!out_valid || out_ready) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // phase outputs
  always_comb begin
    in_ready  = phase == PH_IDLE;
    seq_start = accept && (is_push ? !full : !(empty_now || last_one));
    seq_entry = is_push ? S_UP_CHK : S_POP_RD;
    out_load  = (phase == PH_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  bmhq_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (seq_start),
    .entry (seq_entry),
    .flags (flags),
    .ctl   (ctl)
  );

  // ram address and write data selection
  always_comb begin
    unique case (ctl.rd)
      RD_NONE:   ram_raddr = '0;
      RD_PARENT: ram_raddr = parent;
      RD_COUNT:  ram_raddr = cnt[AW-1:0];
      RD_LEFT:   ram_raddr = left_w[AW-1:0];
      RD_RIGHT:  ram_raddr = right_w[AW-1:0];
      default:   ram_raddr = '0;
    endcase
    unique case (ctl.wr)
      WR_NONE:  ram_wdata = '0;
      WR_RDATA: ram_wdata = rdata;
      WR_BIG:   ram_wdata = bigv;
      WR_CUR:   ram_wdata = cur;
      default:  ram_wdata = '0;
    endcase
  end

  assign ram_re = ctl.rd != RD_NONE;
  assign ram_we = ctl.wr != WR_NONE;

  bmhq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (HEAP_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      if (is_push && !full) begin
        cnt <= cnt + CW'(1);
      end else if (!is_push && !empty_now) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // hole position, moving value, drop flag, left child and root copy
  always_ff @(posedge clk) begin
    if (accept) begin
      dropped <= is_push && full;
      cur     <= in_item.push_value;
      pos     <= cnt[AW-1:0];
    end else begin
      if (ctl.ld_cur) begin
        cur <= rdata;
      end
      unique case (ctl.po)
        PO_HOLD:   pos <= pos;
        PO_CLEAR:  pos <= '0;
        PO_PARENT: pos <= parent;
        PO_BIG:    pos <= big_idx;
        default:   pos <= pos;
      endcase
    end
    if (ctl.ld_lv) begin
      lv <= rdata;
    end
    // slot zero mirrored so the maximum needs no read
    if (ram_we && (pos == '0)) begin
      root <= ram_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.top_value    <= top;
      out_item.is_empty     <= empty_now;
      out_item.entry_count  <= ENTRY_W'(cnt);
      out_item.push_dropped <= dropped;
    end
  end

  `BMHQ_ASSERT(a_cnt_bound, clk, rst, cnt <= CW'(HEAP_CAPACITY))
  `BMHQ_ASSERT(a_wr_in_run, clk, rst, (ctl.wr != WR_NONE) |-> (phase == PH_RUN))
  `BMHQ_ASSERT(a_rose_from_done, clk, rst, $rose(out_valid) |-> $past(phase == PH_DONE))
  `BMHQ_ASSERT(a_empty_zero, clk, rst, (out_valid && out_item.is_empty) |-> (out_item.top_value == '0))
  `BMHQ_ASSERT_NEXT(a_drop_keeps, clk, rst, accept && is_push && full, $stable(cnt))

endmodule

// ===== rtl/bmhq_ram.sv =====
// generic single write port ram with registered read
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bmhq_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
module bmhq_seq
  import bmhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  step_t       entry,
  input  cond_flags_t flags,
  output seq_ctrl_t   ctl
);

  logic  running;
  step_t step;
  ucw_t  word;
  logic  taken;

  always_comb begin
    word = ucode(step);
    unique case (word.jc)
      JC_NEVER:    taken = 1'b0;
      JC_POS_ZERO: taken = flags.pos_zero;
      JC_UP_STOP:  taken = flags.up_stop;
      JC_NO_LEFT:  taken = flags.no_left;
      JC_DN_STOP:  taken = flags.dn_stop;
      default:     taken = 1'b0;
    endcase
  end

  // a taken jump suppresses the step's actions
  always_comb begin
    ctl.rd     = (running && !taken) ? word.rd : RD_NONE;
    ctl.wr     = (running && !taken) ? word.wr : WR_NONE;
    ctl.po     = (running && !taken) ? word.po : PO_HOLD;
    ctl.ld_cur = running && !taken && word.ld_cur;
    ctl.ld_lv  = running && !taken && word.ld_lv;
    ctl.done   = running && word.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= S_UP_CHK;
    end else if (start) begin
      running <= 1'b1;
      step    <= entry;
    end else if (running) begin
      if (word.done) begin
        running <= 1'b0;
      end else begin
        step <= taken ? word.t_true : word.t_false;
      end
    end
  end

endmodule

// ===== tb/heap_queue_check_pkg.sv =====
`timescale 1ns / 1ps
// heap model and result checker for the max-heap queue testbench
package heap_queue_check_pkg;
  import bmhq_pkg::*;

  localparam int HEAP_SLOTS = 1024;

  class heap_result_checker;
    logic signed [DATA_W-1:0] slots [HEAP_SLOTS];
    int unsigned depth = 0;
    out_t expected_results [$];
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned pushes = 0;
    int unsigned drops = 0;
    int unsigned pops = 0;
    int unsigned empty_pops = 0;
    int unsigned peak = 0;

    // apply one accepted request to the heap and queue the result it causes
    function void note_request(in_t req);
      out_t res;
      logic signed [DATA_W-1:0] tmp;
      int unsigned pos;
      int unsigned parent;
      int unsigned left;
      int unsigned big;
      bit walking;
      res = '0;
      if (req.req_type == REQ_PUSH) begin
        pushes++;
        if (depth >= HEAP_SLOTS) begin
          drops++;
          res.push_dropped = 1'b1;
        end else begin
          slots[depth] = req.push_value;
          pos = depth;
          depth++;
          walking = 1'b1;
          // climb while strictly greater than the parent
          while (walking && pos > 0) begin
            parent = (pos - 1) / 2;
            if (slots[pos] <= slots[parent]) begin
              walking = 1'b0;
            end else begin
              tmp = slots[pos];
              slots[pos] = slots[parent];
              slots[parent] = tmp;
              pos = parent;
            end
          end
        end
      end else begin
        pops++;
        if (depth == 0) begin
          empty_pops++;
        end else begin
          depth--;
          slots[0] = slots[depth];
          pos = 0;
          walking = 1'b1;
          // sink toward the larger child, left one on a tie
          while (walking) begin
            left = 2 * pos + 1;
            if (left >= depth) begin
              walking = 1'b0;
            end else begin
              big = left;
              if (left + 1 < depth && slots[left + 1] > slots[left]) big = left + 1;
              if (slots[pos] >= slots[big]) begin
                walking = 1'b0;
              end else begin
                tmp = slots[pos];
                slots[pos] = slots[big];
                slots[big] = tmp;
                pos = big;
              end
            end
          end
        end
      end
      if (depth > peak) peak = depth;
      res.top_value = (depth > 0) ? slots[0] : '0;
      res.is_empty = (depth == 0);
      res.entry_count = depth[ENTRY_W-1:0];
      expected_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: top %0d empty %0b count %0d dropped %0b",
                   got.top_value, got.is_empty, got.entry_count, got.push_dropped);
        return;
      end
      want = expected_results.pop_front();
      if (got.top_value !== want.top_value || got.is_empty !== want.is_empty ||
          got.entry_count !== want.entry_count || got.push_dropped !== want.push_dropped) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d: want top %0d empty %0b count %0d dropped %0b, ",
                    "got top %0d empty %0b count %0d dropped %0b"},
                   checked, want.top_value, want.is_empty, want.entry_count,
                   want.push_dropped, got.top_value, got.is_empty, got.entry_count,
                   got.push_dropped);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function bit failed();
      return mismatches != 0 || expected_results.size() != 0;
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench top: random push/pop traffic into the heap queue, every result checked
module tb;
  import bmhq_pkg::*;
  import heap_queue_check_pkg::*;

  // cycles with no handshake on either side before the run is declared hung
  localparam int IDLE_LIMIT = 4000;
  // cycles to watch for stray results once everything expected has arrived
  localparam int SETTLE_CYCLES = 40;
  localparam int MIXED_ITEMS = 200;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PATTERN
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  heap_result_checker heap_check;

  int idle_cycles = 0;
  int burst_left = 0;

  ready_mode_t ready_mode = RDY_ALWAYS;
  int mode_left = 0;
  int ready_phase = 0;
  logic [7:0] ready_pattern = 8'h01;

  binary_max_heap_queue_unit #(
    .HEAP_CAPACITY(HEAP_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always #4 clk = ~clk;

  // sample both channels at the rising edge; inputs only move at the falling edge
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && in_ready) heap_check.note_request(in_item);
      if (out_valid && out_ready) heap_check.check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        // nothing moved for too long: the block is hung
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  // receiver backpressure: a random mode held for a random stretch
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 200);
      // at least one ready slot per pattern so it never locks up
      ready_pattern = 8'($urandom_range(0, 255)) | 8'h01;
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS: out_ready = 1'b1;
      RDY_COIN: out_ready = 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready = ($urandom_range(0, 4) == 0);
      default: begin
        out_ready = ready_pattern[ready_phase];
        ready_phase = (ready_phase + 1) % 8;
      end
    endcase
  end

  // mostly full-range values, plus extremes and a narrow band that forces ties
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // present one item, bursts of random length separated by random gaps;
  // returns on the falling edge after the item was accepted
  task automatic send_request(input logic kind, input logic signed [DATA_W-1:0] value);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = '{req_type: kind, push_value: value};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic push_value(input logic signed [DATA_W-1:0] value);
    send_request(REQ_PUSH, value);
  endtask

  task automatic pop_max();
    send_request(REQ_POP, $urandom);
  endtask

  // hold the sender until every expected result is back
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (heap_check.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int overflow_pushes;
    heap_check = new;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: pop on empty, extremes, ties, draining to empty and past it
    pop_max();
    push_value(5);
    push_value(5);
    push_value(VAL_MAX);
    push_value(VAL_MIN);
    push_value(0);
    push_value(-1);
    push_value(5);
    push_value(3);
    repeat (9) pop_max();
    push_value(VAL_MIN);
    pop_max();

    // mixed traffic, slightly push heavy so the heap grows a few levels
    repeat (MIXED_ITEMS) begin
      if ($urandom_range(0, 99) < 55) push_value(pick_value());
      else pop_max();
    end
    wait_for_results();

    // fill to capacity and keep pushing so some pushes get refused
    overflow_pushes = 0;
    while (overflow_pushes < 8) begin
      if ($urandom_range(0, 19) == 0) begin
        pop_max();
      end else begin
        if (heap_check.depth == HEAP_SLOTS) overflow_pushes++;
        push_value(pick_value());
      end
    end
    wait_for_results();

    // drain back to empty with the odd push, then pop an empty heap
    while (heap_check.depth != 0) begin
      if ($urandom_range(0, 11) == 0) push_value(pick_value());
      else pop_max();
    end
    repeat (4) pop_max();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d pushes (%0d refused on a full heap), %0d pops (%0d on empty)",
             heap_check.pushes, heap_check.drops, heap_check.pops, heap_check.empty_pops);
    $display("peak depth %0d, %0d results checked, %0d mismatches",
             heap_check.peak, heap_check.checked, heap_check.mismatches);
    if (heap_check.failed()) begin
      $display("tb NOT OK");
    end else begin
      $display("tb OK");
    end
    $finish;
  end

endmodule
